[hdl/ttg_pkg.sv]
// Shared types and constants for the triangle tangent generator.
package ttg_pkg;

    localparam int VERTEX_DEPTH = 4096;
    localparam int IDX_W        = $clog2(VERTEX_DEPTH);
    localparam int FRAC         = 14;
    localparam int OUT_W        = 16;
    localparam int SM_W         = 30;
    localparam int L_W          = SM_W + 1;
    localparam int REM_W        = SM_W + FRAC + 1;
    localparam int Q_W          = FRAC + 1;

    typedef enum logic [1:0] {
        ACT_LOAD = 2'd0,
        ACT_TRI  = 2'd1,
        ACT_READ = 2'd2,
        ACT_NONE = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic [11:0]        slot_idx;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
        logic [11:0]        corner_a;
        logic [11:0]        corner_b;
        logic [11:0]        corner_c;
    } t_item;

    typedef struct packed {
        logic signed [15:0] tangent_x;
        logic signed [15:0] tangent_y;
        logic signed [15:0] tangent_z;
        logic               handedness_negative;
        logic               degenerate;
    } t_result;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] tex_u;
        logic signed [15:0] tex_v;
    } t_vert;

    typedef struct packed {
        logic             is_tri;
        logic [IDX_W-1:0] ridx;
        logic [IDX_W-1:0] ca;
        logic [IDX_W-1:0] cb;
        logic [IDX_W-1:0] cc;
    } t_side;

    typedef struct packed {
        t_side                   sd;
        logic [2:0][32:0]        e1;
        logic [2:0][32:0]        e2;
        logic signed [16:0]      du1;
        logic signed [16:0]      dv1;
        logic signed [16:0]      du2;
        logic signed [16:0]      dv2;
    } t_job;

    typedef struct packed {
        t_side            sd;
        logic [OUT_W-1:0] tx;
        logic [OUT_W-1:0] ty;
        logic [OUT_W-1:0] tz;
        logic             hneg;
        logic             degen;
    } t_mres;

endpackage

[hdl/ttg_front.sv]
// Front end: vertex store, corner fetch and edge/texture delta formation.
module ttg_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          push,
    output logic          full,
    input  ttg_pkg::t_item i_item,
    input  logic          i_jq_full,
    output logic          o_push0,
    output ttg_pkg::t_job o_job0,
    output logic          o_push1,
    output ttg_pkg::t_job o_job1
);

    typedef enum logic [1:0] {S_IDLE, S_RB, S_RC, S_PUSH} t_state;

    t_state r_state, n_state;
    ttg_pkg::t_vert r_mem [ttg_pkg::VERTEX_DEPTH];
    ttg_pkg::t_vert r_rd, r_va;
    logic [ttg_pkg::IDX_W-1:0] r_ca, r_cb, r_cc, rd_addr;
    logic [2:0][32:0] r_e1;
    logic signed [16:0] r_du1, r_dv1;
    logic acc;

    assign full    = (r_state == S_RB) || (r_state == S_RC) || i_jq_full;
    assign acc     = push && !full;
    assign o_push0 = (r_state == S_PUSH) && !i_jq_full;
    assign o_push1 = acc && (i_item.action == ttg_pkg::ACT_READ);

    always_comb begin
        case (r_state)
            S_RB:    rd_addr = r_cb;
            S_RC:    rd_addr = r_cc;
            default: rd_addr = i_item.corner_a;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RB:    n_state = S_RC;
            S_RC:    n_state = S_PUSH;
            default: begin
                if (r_state == S_PUSH && i_jq_full) begin
                    n_state = S_PUSH;
                end else if (acc && i_item.action == ttg_pkg::ACT_TRI) begin
                    n_state = S_RB;
                end else begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_comb begin
        o_job0         = '0;
        o_job0.sd      = '{is_tri: 1'b1, ridx: '0, ca: r_ca, cb: r_cb, cc: r_cc};
        o_job0.e1      = r_e1;
        o_job0.e2[0]   = 33'(r_rd.pos_x) - 33'(r_va.pos_x);
        o_job0.e2[1]   = 33'(r_rd.pos_y) - 33'(r_va.pos_y);
        o_job0.e2[2]   = 33'(r_rd.pos_z) - 33'(r_va.pos_z);
        o_job0.du1     = r_du1;
        o_job0.dv1     = r_dv1;
        o_job0.du2     = 17'(r_rd.tex_u) - 17'(r_va.tex_u);
        o_job0.dv2     = 17'(r_rd.tex_v) - 17'(r_va.tex_v);
        o_job1         = '0;
        o_job1.sd.ridx = i_item.slot_idx;
    end

    always_ff @(posedge i_clk) begin
        if (acc && i_item.action == ttg_pkg::ACT_LOAD) begin
            r_mem[i_item.slot_idx] <= '{pos_x: i_item.pos_x, pos_y: i_item.pos_y,
                                        pos_z: i_item.pos_z, tex_u: i_item.tex_u,
                                        tex_v: i_item.tex_v};
        end
        // corner c must stay put while the job waits for queue space
        if (!(r_state == S_PUSH && i_jq_full)) begin
            r_rd <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if (acc && i_item.action == ttg_pkg::ACT_TRI) begin
            r_ca <= i_item.corner_a;
            r_cb <= i_item.corner_b;
            r_cc <= i_item.corner_c;
        end
        if (r_state == S_RB) begin
            r_va <= r_rd;
        end
        if (r_state == S_RC) begin
            r_e1[0] <= 33'(r_rd.pos_x) - 33'(r_va.pos_x);
            r_e1[1] <= 33'(r_rd.pos_y) - 33'(r_va.pos_y);
            r_e1[2] <= 33'(r_rd.pos_z) - 33'(r_va.pos_z);
            r_du1   <= 17'(r_rd.tex_u) - 17'(r_va.tex_u);
            r_dv1   <= 17'(r_rd.tex_v) - 17'(r_va.tex_v);
        end
    end

endmodule

[hdl/ttg_jobq.sv]
// Four-entry job queue between front and back, two pushes per cycle.
module ttg_jobq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push0,
    input  ttg_pkg::t_job i_job0,
    input  logic          i_push1,
    input  ttg_pkg::t_job i_job1,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ttg_pkg::t_job o_job
);

    ttg_pkg::t_job r_q [4];
    logic [1:0] r_wp, r_rp, wp1;
    logic [2:0] r_cnt;

    assign o_full  = r_cnt > 3'd2;
    assign o_empty = r_cnt == 3'd0;
    assign o_job   = r_q[r_rp];
    assign wp1     = r_wp + 2'(i_push0);

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_q[r_wp] <= i_job0;
        end
        if (i_push1) begin
            r_q[wp1] <= i_job1;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + 2'(i_push0) + 2'(i_push1);
            r_rp  <= r_rp + 2'(i_pop);
            r_cnt <= r_cnt + 3'(i_push0) + 3'(i_push1) - 3'(i_pop);
        end
    end

endmodule

[hdl/ttg_math.sv]
// Back-end arithmetic pipeline: raw tangent, scaling, square root, divide, sign.
module ttg_math (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ttg_pkg::t_job  i_job,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output ttg_pkg::t_mres o_res
);

    localparam int SQ_N = 32;
    localparam int DV_N = ttg_pkg::Q_W;
    localparam int NST  = 6 + SQ_N + 1 + DV_N + 1;

    typedef struct packed {
        ttg_pkg::t_side                    sd;
        logic [2:0][ttg_pkg::SM_W-1:0]     sm;
        logic [2:0]                        neg;
        logic                              hneg;
        logic                              degen;
    } t_tail;

    logic en;
    logic [NST-1:0] r_v;

    ttg_pkg::t_side r1_sd, r2_sd, r3_sd;
    logic signed [49:0] r1_p1 [3];
    logic signed [49:0] r1_p2 [3];
    logic signed [33:0] r1_d1, r1_d2;
    logic [49:0] r2_mag [3];
    logic [49:0] n2_mag [3];
    logic [2:0] r2_neg, n2_neg, r3_neg;
    logic r2_hneg, r2_dz, n2_hneg, n2_dz, r3_hneg, r3_degen, n3_degen;
    logic signed [50:0] raw [3];
    logic signed [34:0] dd;
    logic [49:0] r3_mag [3];
    logic [49:0] orv;
    logic [5:0] blen;
    logic [4:0] r3_s, n3_s;
    t_tail r4_tl, r5_tl, n4_tl;
    logic [59:0] r5_sq [3];
    logic [61:0] n6_sum;

    t_tail       r_tl [SQ_N+1];
    logic [61:0] r_sx [SQ_N+1];
    logic [62:0] r_sr [SQ_N+1];
    logic [61:0] n_sx [SQ_N+1];
    logic [62:0] n_sr [SQ_N+1];
    logic [62:0] bitv [SQ_N];
    logic [62:0] tr [SQ_N];

    t_tail                    r_dtl [DV_N+1];
    logic [ttg_pkg::L_W-1:0]  r_dl  [DV_N+1];
    logic [ttg_pkg::REM_W-1:0] r_rem [DV_N+1][3];
    logic [ttg_pkg::Q_W-1:0]  r_q   [DV_N+1][3];
    logic [ttg_pkg::REM_W-1:0] n_rem [DV_N+1][3];
    logic [ttg_pkg::Q_W-1:0]  n_q   [DV_N+1][3];
    logic [ttg_pkg::REM_W:0]  dsh   [DV_N][3];
    logic [ttg_pkg::L_W-1:0]  lsq;

    ttg_pkg::t_mres r_out, n_out;
    logic [ttg_pkg::OUT_W-1:0] ov [3];

    assign en      = !i_stall;
    assign o_pop   = en && i_valid;
    assign o_valid = r_v[NST-1];
    assign o_res   = r_out;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            raw[k]    = 51'(r1_p1[k]) - 51'(r1_p2[k]);
            n2_neg[k] = raw[k][50];
            n2_mag[k] = raw[k][50] ? 50'(-raw[k]) : 50'(raw[k]);
        end
        dd      = 35'(r1_d1) - 35'(r1_d2);
        n2_dz   = dd == '0;
        n2_hneg = !dd[34] && !n2_dz;

        orv  = r2_mag[0] | r2_mag[1] | r2_mag[2];
        blen = '0;
        for (int b = 0; b < 50; b++) begin
            if (orv[b]) begin
                blen = 6'(b + 1);
            end
        end
        n3_s     = (blen > 6'd30) ? 5'(blen - 6'd30) : '0;
        n3_degen = r2_dz || (orv == '0);

        n4_tl.sd    = r3_sd;
        n4_tl.neg   = r3_neg;
        n4_tl.hneg  = r3_hneg;
        n4_tl.degen = r3_degen;
        for (int k = 0; k < 3; k++) begin
            n4_tl.sm[k] = ttg_pkg::SM_W'(r3_mag[k] >> r3_s);
        end

        n6_sum = 62'(r5_sq[0]) + 62'(r5_sq[1]) + 62'(r5_sq[2]);

        n_sx[0] = '0;
        n_sr[0] = '0;
        for (int j = 0; j < SQ_N; j++) begin
            bitv[j] = 63'(1) << (62 - 2 * j);
            tr[j]   = r_sr[j] + bitv[j];
            if ({1'b0, r_sx[j]} >= tr[j]) begin
                n_sx[j+1] = r_sx[j] - 62'(tr[j]);
                n_sr[j+1] = (r_sr[j] >> 1) + bitv[j];
            end else begin
                n_sx[j+1] = r_sx[j];
                n_sr[j+1] = r_sr[j] >> 1;
            end
        end

        lsq = ttg_pkg::L_W'(r_sr[SQ_N]);
        for (int k = 0; k < 3; k++) begin
            n_rem[0][k] = {1'b0, r_tl[SQ_N].sm[k], ttg_pkg::FRAC'(0)}
                        + ttg_pkg::REM_W'(lsq >> 1);
            n_q[0][k]   = '0;
        end
        for (int t = 0; t < DV_N; t++) begin
            for (int k = 0; k < 3; k++) begin
                dsh[t][k] = (ttg_pkg::REM_W+1)'(r_dl[t]) << (DV_N - 1 - t);
                n_q[t+1][k] = r_q[t][k];
                if ({1'b0, r_rem[t][k]} >= dsh[t][k]) begin
                    n_rem[t+1][k] = r_rem[t][k] - ttg_pkg::REM_W'(dsh[t][k]);
                    n_q[t+1][k][DV_N-1-t] = 1'b1;
                end else begin
                    n_rem[t+1][k] = r_rem[t][k];
                end
            end
        end

        for (int k = 0; k < 3; k++) begin
            if (r_dtl[DV_N].degen) begin
                ov[k] = '0;
            end else if (!r_dtl[DV_N].neg[k]) begin
                ov[k] = -ttg_pkg::OUT_W'(r_q[DV_N][k]);
            end else begin
                ov[k] = ttg_pkg::OUT_W'(r_q[DV_N][k]);
            end
        end
        n_out.sd    = r_dtl[DV_N].sd;
        n_out.tx    = ov[0];
        n_out.ty    = ov[1];
        n_out.tz    = ov[2];
        n_out.hneg  = r_dtl[DV_N].hneg;
        n_out.degen = r_dtl[DV_N].degen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NST-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_sd <= i_job.sd;
            for (int k = 0; k < 3; k++) begin
                r1_p1[k] <= $signed(i_job.e1[k]) * i_job.dv2;
                r1_p2[k] <= $signed(i_job.e2[k]) * i_job.dv1;
            end
            r1_d1 <= i_job.du1 * i_job.dv2;
            r1_d2 <= i_job.du2 * i_job.dv1;

            r2_sd   <= r1_sd;
            r2_mag  <= n2_mag;
            r2_neg  <= n2_neg;
            r2_hneg <= n2_hneg;
            r2_dz   <= n2_dz;

            r3_sd    <= r2_sd;
            r3_mag   <= r2_mag;
            r3_neg   <= r2_neg;
            r3_hneg  <= r2_hneg;
            r3_degen <= n3_degen;
            r3_s     <= n3_s;

            r4_tl <= n4_tl;

            r5_tl <= r4_tl;
            for (int k = 0; k < 3; k++) begin
                r5_sq[k] <= r4_tl.sm[k] * r4_tl.sm[k];
            end

            r_tl[0] <= r5_tl;
            r_sx[0] <= n6_sum;
            r_sr[0] <= '0;
            for (int j = 0; j < SQ_N; j++) begin
                r_tl[j+1] <= r_tl[j];
                r_sx[j+1] <= n_sx[j+1];
                r_sr[j+1] <= n_sr[j+1];
            end

            r_dtl[0] <= r_tl[SQ_N];
            r_dl[0]  <= lsq;
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            for (int t = 0; t < DV_N; t++) begin
                r_dtl[t+1] <= r_dtl[t];
                r_dl[t+1]  <= r_dl[t];
                r_rem[t+1] <= n_rem[t+1];
                r_q[t+1]   <= n_q[t+1];
            end

            r_out <= n_out;
        end
    end

endmodule

[hdl/ttg_wb.sv]
// Write-back: tangent store updates, readback and the result queue.
module ttg_wb (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  ttg_pkg::t_mres   i_res,
    output logic             o_stall,
    input  logic             pop,
    output logic             empty,
    output ttg_pkg::t_result o_result
);

    logic [3*ttg_pkg::OUT_W-1:0] r_tmem [ttg_pkg::VERTEX_DEPTH];
    logic [3*ttg_pkg::OUT_W-1:0] r_rdata, wdata;
    logic [ttg_pkg::IDX_W-1:0] waddr;
    ttg_pkg::t_mres r_w;
    logic r_wv;
    logic [1:0] r_cnt;
    logic we, ofull, w_done, ld, opop;

    ttg_pkg::t_result r_oq [4];
    ttg_pkg::t_result res;
    logic [1:0] r_owp, r_orp;
    logic [2:0] r_ocnt;

    assign ofull    = r_ocnt == 3'd4;
    assign w_done   = r_wv && !ofull && (!r_w.sd.is_tri || r_cnt == 2'd2);
    assign o_stall  = r_wv && !w_done;
    assign ld       = !o_stall;
    assign we       = r_wv && r_w.sd.is_tri;
    assign wdata    = {r_w.tz, r_w.ty, r_w.tx};
    assign empty    = r_ocnt == 3'd0;
    assign opop     = pop && !empty;
    assign o_result = r_oq[r_orp];

    always_comb begin
        case (r_cnt)
            2'd0:    waddr = r_w.sd.ca;
            2'd1:    waddr = r_w.sd.cb;
            default: waddr = r_w.sd.cc;
        endcase
        if (r_w.sd.is_tri) begin
            res = '{tangent_x: r_w.tx, tangent_y: r_w.ty, tangent_z: r_w.tz,
                    handedness_negative: r_w.hneg, degenerate: r_w.degen};
        end else begin
            res = '{tangent_x: r_rdata[15:0], tangent_y: r_rdata[31:16],
                    tangent_z: r_rdata[47:32], handedness_negative: 1'b0,
                    degenerate: 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_tmem[waddr] <= wdata;
        end
        if (ld && i_valid && !i_res.sd.is_tri) begin
            r_rdata <= (we && waddr == i_res.sd.ridx) ? wdata : r_tmem[i_res.sd.ridx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld) begin
            r_w <= i_res;
        end
        if (w_done) begin
            r_oq[r_owp] <= res;
        end
        if (!i_rst_n) begin
            r_wv   <= 1'b0;
            r_cnt  <= '0;
            r_owp  <= '0;
            r_orp  <= '0;
            r_ocnt <= '0;
        end else begin
            if (ld) begin
                r_wv  <= i_valid;
                r_cnt <= '0;
            end else if (r_cnt != 2'd2) begin
                r_cnt <= r_cnt + 2'd1;
            end
            r_owp  <= r_owp + 2'(w_done);
            r_orp  <= r_orp + 2'(opop);
            r_ocnt <= r_ocnt + 3'(w_done) - 3'(opop);
        end
    end

endmodule

[hdl/triangle_tangent_generator_unit.sv]
// Top level of the per-triangle tangent generator.
// Input channel: push/full with one item on i_item. A load item writes one
// vertex, a triangle item computes and stores the tangent of three corners and
// returns it, a read item returns a stored tangent, action 3 is dropped.
// Result channel: empty/pop; the oldest result sits on o_result while empty
// is low. Loads and action 3 give no result.
// Throughput of triangles is bounded by the three corner reads on the
// single vertex store port and the three writes to the tangent store port.
// Loads and reads can be accepted back to back while full is low.
// A triangle passes the corner fetch, the job queue, the arithmetic stages
// incl. a 32-step square root and 15-step divide, and write-back; a read
// skips the corner fetch.
// When pop stays low, the result queue fills, write-back and the arithmetic
// pipeline hold, and full rises once the job queue cannot take two more jobs.
// Reset clears all handshake and queue control; the vertex and tangent stores
// keep their content and are undefined until written.
module triangle_tangent_generator_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  ttg_pkg::t_item   i_item,
    output logic             empty,
    input  logic             pop,
    output ttg_pkg::t_result o_result
);

    logic jq_full, jq_empty, push0, push1, jq_pop, m_valid, wb_stall;
    ttg_pkg::t_job job0, job1, jq_job;
    ttg_pkg::t_mres m_res;

    ttg_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_item    (i_item),
        .i_jq_full (jq_full),
        .o_push0   (push0),
        .o_job0    (job0),
        .o_push1   (push1),
        .o_job1    (job1)
    );

    ttg_jobq u_jobq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (push0),
        .i_job0  (job0),
        .i_push1 (push1),
        .i_job1  (job1),
        .o_full  (jq_full),
        .i_pop   (jq_pop),
        .o_empty (jq_empty),
        .o_job   (jq_job)
    );

    ttg_math u_math (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!jq_empty),
        .i_job   (jq_job),
        .o_pop   (jq_pop),
        .i_stall (wb_stall),
        .o_valid (m_valid),
        .o_res   (m_res)
    );

    ttg_wb u_wb (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (m_valid),
        .i_res    (m_res),
        .o_stall  (wb_stall),
        .pop      (pop),
        .empty    (empty),
        .o_result (o_result)
    );

endmodule
